### rtl/lfu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants for the LFU block cache.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int MAX_ENTRIES     = 256;
  localparam int BLOCK_WORDS     = 32;
  localparam int NUM_DISKS       = 16;
  localparam int USE_COUNT_WIDTH = 16;

  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int WRD_W  = $clog2(BLOCK_WORDS);
  localparam int CPY_W  = $clog2(BLOCK_WORDS + 1);
  localparam int DADR_W = IDX_W + WRD_W;

  localparam logic [USE_COUNT_WIDTH-1:0] USE_MAX = '1;

  // operation codes
  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_UPDATE = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISS     = 2'd1;
  localparam logic [1:0] ST_DISABLED = 2'd2;
  localparam logic [1:0] ST_DUP      = 2'd3;

  // register indexes
  localparam logic REG_ENABLED = 1'b0;
  localparam logic REG_ENTRIES = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_COPY,
    S_TAGWR,
    S_DREAD,
    S_DLOAD,
    S_SEND
  } state_t;

  typedef struct packed {
    logic [3:0]                 disk;
    logic [7:0]                 block;
    logic [USE_COUNT_WIDTH-1:0] uses;
  } tag_t;

endpackage

### rtl/lfu_block_cache_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_block_cache_core
// Fully associative block cache keyed by (disk, block), LFU replacement.
// ----------------------------------------------------------------------------
// Usage:
//  Input words arrive on s_t*: func in s_tuser, key and one data word in
//  s_tdata. Results leave on m_t*, one word per handshake, m_tlast on the
//  final word of each run. Registers (enabled, entries_in_use) sit on an
//  APB port at byte addresses 0 and 4; any write clears the store.
//  One word is worked on at a time; s_tready is high only when idle.
//  A single tag port is stepped over the active entries, one entry a cycle,
//  for a lookup or a completing write. A write that finds its slot copies
//  the block through the staging buffer into data memory. A lookup hit
//  streams 32 words through the data memory read port, each word passing
//  through the read, load and send states in turn.
//  While enabled, a staging word that does not complete a block is only stored.
//  A stalled receiver simply holds the sequencer in its send state; the
//  result stays put and no input is taken until it drains.
//  Reset clears valid bits, staging count and the counters at once; no
//  clearing pass is needed.
// ----------------------------------------------------------------------------
module lfu_block_cache_core (
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [79:0]  s_tdata,   // disk[3:0], block[11:4], data_word[75:12], pad
  input  logic [1:0]   s_tuser,   // func[1:0]
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,   // status[1:0], read_word[65:2], hit_total[97:66],
                                  // query_total[129:98], pad
  output logic         m_tlast,   // last_word
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import lfu_pkg::*;

  state_t state, state_next;

  // config registers
  logic             enabled;
  logic [CNT_W-1:0] entries_in_use;

  // memories
  tag_t        tag_mem   [MAX_ENTRIES];
  logic [63:0] data_mem  [MAX_ENTRIES*BLOCK_WORDS];
  logic [63:0] stage_mem [BLOCK_WORDS];
  logic [MAX_ENTRIES-1:0] entry_valid;

  // work registers
  logic [WRD_W-1:0] staging_count;
  logic [31:0]      hit_counter, query_counter;
  logic [1:0]       op;
  logic [3:0]       key_disk;
  logic [7:0]       key_block;
  logic [CNT_W-1:0] scan_cnt;
  logic             chk_live;
  logic [IDX_W-1:0] chk_idx;
  tag_t             tag_q;
  logic             valid_q;
  logic [USE_COUNT_WIDTH-1:0] best_uses;
  logic [IDX_W-1:0] tgt;
  tag_t             hit_tag;
  logic [CPY_W-1:0] cp_cnt;
  logic [63:0]      stage_q, data_q;
  logic [WRD_W-1:0] word_idx;
  logic [1:0]       out_status;
  logic [63:0]      out_word;
  logic             out_last;

  logic       cfg_wr, in_acc, out_acc;
  logic [1:0] in_func;
  logic [3:0] in_disk;
  logic [7:0] in_block;
  logic       chk_last, key_match, eval, better;
  logic [8:0] cfg_ent;
  tag_t       tag_wr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign in_acc  = s_tvalid & s_tready;
  assign out_acc = m_tvalid & m_tready;
  assign in_func  = s_tuser;
  assign in_disk  = s_tdata[3:0];
  assign in_block = s_tdata[11:4];

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_SEND);
  assign m_tlast  = out_last;
  assign m_tdata  = {6'd0, query_counter, hit_counter, out_word, out_status};

  // register read back
  always_comb begin
    case (paddr[2])
      REG_ENABLED: prdata = {31'd0, enabled};
      REG_ENTRIES: prdata = {{(32-CNT_W){1'b0}}, entries_in_use};
      default:     prdata = 32'd0;
    endcase
  end

  // entries_in_use clamp into [2, MAX_ENTRIES]
  always_comb begin
    cfg_ent = pwdata[8:0];
    if (cfg_ent < 9'd2) cfg_ent = 9'd2;
    if (cfg_ent > 9'(MAX_ENTRIES)) cfg_ent = 9'(MAX_ENTRIES);
  end

  // scan compare on the registered tag read
  assign eval      = (state == S_SCAN) && chk_live;
  assign chk_last  = ({1'b0, chk_idx} == entries_in_use - CNT_W'(1));
  assign key_match = (tag_q.disk == key_disk) && (tag_q.block == key_block);
  assign better    = (chk_idx == '0) || (tag_q.uses < best_uses);

  // tag write word: fresh entry on insert, use bump otherwise
  always_comb begin
    tag_wr = hit_tag;
    if (op == FUNC_INSERT) begin
      tag_wr.disk  = key_disk;
      tag_wr.block = key_block;
      tag_wr.uses  = USE_COUNT_WIDTH'(1);
    end else if (hit_tag.uses != USE_MAX) begin
      tag_wr.uses = hit_tag.uses + USE_COUNT_WIDTH'(1);
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc && in_func != FUNC_NONE) begin
          if (!enabled) state_next = S_SEND;
          else if (in_func == FUNC_LOOKUP) state_next = S_SCAN;
          else if (staging_count == WRD_W'(BLOCK_WORDS-1)) begin
            if (in_func == FUNC_INSERT && {1'b0, in_disk} >= 5'(NUM_DISKS))
              state_next = S_SEND;
            else
              state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (eval) begin
          if (op == FUNC_INSERT) begin
            if (!valid_q) state_next = S_COPY;
            else if (key_match) state_next = S_SEND;
            else if (chk_last) state_next = S_COPY;
          end else if (valid_q && key_match) begin
            state_next = (op == FUNC_LOOKUP) ? S_TAGWR : S_COPY;
          end else if (chk_last) begin
            state_next = S_SEND;
          end
        end
      end
      S_COPY:  if (cp_cnt == CPY_W'(BLOCK_WORDS)) state_next = S_TAGWR;
      S_TAGWR: state_next = (op == FUNC_LOOKUP) ? S_DREAD : S_SEND;
      S_DREAD: state_next = S_DLOAD;
      S_DLOAD: state_next = S_SEND;
      S_SEND: begin
        if (out_acc) state_next = m_tlast ? S_IDLE : S_DREAD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled        <= 1'b0;
      entries_in_use <= CNT_W'(2);
      entry_valid    <= '0;
      staging_count  <= '0;
      hit_counter    <= '0;
      query_counter  <= '0;
      chk_live       <= 1'b0;
    end else begin
      chk_live <= (state == S_SCAN) && (scan_cnt < entries_in_use);
      if (cfg_wr) begin
        if (paddr[2] == REG_ENABLED) enabled <= pwdata[0];
        else                         entries_in_use <= cfg_ent;
        entry_valid   <= '0;
        staging_count <= '0;
      end
      if (in_acc && enabled) begin
        if (in_func == FUNC_LOOKUP) begin
          if (query_counter != '1) query_counter <= query_counter + 32'd1;
        end else if (in_func != FUNC_NONE) begin
          staging_count <= staging_count + WRD_W'(1);
        end
      end
      if (eval && op == FUNC_LOOKUP && valid_q && key_match && hit_counter != '1)
        hit_counter <= hit_counter + 32'd1;
      if (state == S_TAGWR && op == FUNC_INSERT)
        entry_valid[tgt] <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    valid_q <= entry_valid[scan_cnt[IDX_W-1:0]];
    chk_idx <= scan_cnt[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        op        <= in_func;
        key_disk  <= in_disk;
        key_block <= in_block;
        scan_cnt  <= '0;
        cp_cnt    <= '0;
        word_idx  <= '0;
        out_word  <= '0;
        out_last  <= 1'b1;
        out_status <= enabled ? ST_MISS : ST_DISABLED;
      end
      S_SCAN: begin
        scan_cnt <= scan_cnt + CNT_W'(1);
        if (eval) begin
          if (op == FUNC_INSERT) begin
            if (!valid_q) tgt <= chk_idx;
            else if (key_match) out_status <= ST_DUP;
            else if (better) begin
              tgt       <= chk_idx;
              best_uses <= tag_q.uses;
            end
          end else if (valid_q && key_match) begin
            tgt     <= chk_idx;
            hit_tag <= tag_q;
          end
        end
      end
      S_COPY:  cp_cnt <= cp_cnt + CPY_W'(1);
      S_TAGWR: out_status <= ST_OK;
      S_DLOAD: begin
        out_word   <= data_q;
        out_status <= ST_OK;
        out_last   <= (word_idx == WRD_W'(BLOCK_WORDS-1));
      end
      S_SEND: if (out_acc) word_idx <= word_idx + WRD_W'(1);
      default: ;
    endcase
  end

  // tag memory: one read, one write port
  always_ff @(posedge clk) begin
    tag_q <= tag_mem[scan_cnt[IDX_W-1:0]];
    if (state == S_TAGWR) tag_mem[tgt] <= tag_wr;
  end

  // staging buffer
  always_ff @(posedge clk) begin
    stage_q <= stage_mem[cp_cnt[WRD_W-1:0]];
    if (in_acc && enabled && in_func != FUNC_NONE && in_func != FUNC_LOOKUP)
      stage_mem[staging_count] <= s_tdata[75:12];
  end

  // block data memory
  always_ff @(posedge clk) begin
    data_q <= data_mem[{tgt, word_idx}];
    if (state == S_COPY && cp_cnt != '0)
      data_mem[{tgt, WRD_W'(cp_cnt - CPY_W'(1))}] <= stage_q;
  end

`ifndef NO_ASSERTIONS
  a_hits_le_queries: assert property (@(posedge clk) disable iff (rst)
    hit_counter <= query_counter) else $error("hit count above query count");
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> (staging_count == $past(staging_count)))
    else $error("staging count moved while busy");
  a_copy_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY && cp_cnt == CPY_W'(BLOCK_WORDS)) |=> (state == S_TAGWR))
    else $error("copy did not end in tag write");
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("ready while result pending");
`endif

endmodule

### test/lfu_block_cache_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_block_cache_core_test
// Self-checking bench for the LFU block cache. A scoreboard keeps its own copy
// of the tags, use counts, block data and staging buffer. It predicts each
// result word from the accepted input words and checks the result stream
// against it. Directed cases cover disabled operation, misses, duplicates,
// updates and eviction. Random phases then run lookups and block writes over
// several register settings, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module lfu_block_cache_core_test;
  import lfu_pkg::*;

  typedef struct {
    logic [1:0]  status;
    logic [63:0] rword;
    logic        last;
    logic [31:0] hits;
    logic [31:0] queries;
  } cache_result_t;

  // Cache predictor plus the queue of result words still to come
  class cache_scoreboard;
    bit                        enabled;
    int                        entries;
    bit                        valid [MAX_ENTRIES];
    logic [3:0]                tag_disk [MAX_ENTRIES];
    logic [7:0]                tag_block [MAX_ENTRIES];
    logic [USE_COUNT_WIDTH-1:0] uses [MAX_ENTRIES];
    logic [63:0]               blocks [MAX_ENTRIES][BLOCK_WORDS];
    logic [63:0]               staged [BLOCK_WORDS];
    int                        staged_cnt;
    logic [31:0]               hits;
    logic [31:0]               queries;
    cache_result_t             pending [$];
    int                        errors;

    function void wipe();
      foreach (valid[i]) begin
        valid[i] = 0;
        uses[i] = '0;
      end
      staged_cnt = 0;
    endfunction

    function void reset_state();
      enabled = 0;
      entries = 2;
      hits = '0;
      queries = '0;
      errors = 0;
      wipe();
    endfunction

    function void write_reg(logic r, logic [31:0] val);
      int n;
      if (r == REG_ENABLED) enabled = val[0];
      else begin
        n = int'(val[8:0]);
        if (n < 2) n = 2;
        if (n > MAX_ENTRIES) n = MAX_ENTRIES;
        entries = n;
      end
      wipe();
    endfunction

    function void push(logic [1:0] st, logic [63:0] w, logic last);
      cache_result_t r;
      r.status = st;
      r.rword = w;
      r.last = last;
      r.hits = hits;
      r.queries = queries;
      pending.push_back(r);
    endfunction

    function int find_key(logic [3:0] d, logic [7:0] b);
      for (int i = 0; i < entries; i++)
        if (valid[i] && tag_disk[i] == d && tag_block[i] == b) return i;
      return -1;
    endfunction

    function void bump(int i);
      if (uses[i] != USE_MAX) uses[i]++;
    endfunction

    // One accepted input word
    function void note_word(logic [1:0] f, logic [3:0] d, logic [7:0] b,
                            logic [63:0] w);
      int idx;
      int victim;
      bit have;
      bit dup;
      logic [USE_COUNT_WIDTH-1:0] best;
      if (f == FUNC_NONE) return;
      if (!enabled) begin
        push(ST_DISABLED, '0, 1'b1);
        return;
      end
      if (f == FUNC_LOOKUP) begin
        if (queries != '1) queries++;
        idx = find_key(d, b);
        if (idx < 0) begin
          push(ST_MISS, '0, 1'b1);
          return;
        end
        bump(idx);
        if (hits != '1) hits++;
        for (int i = 0; i < BLOCK_WORDS; i++)
          push(ST_OK, blocks[idx][i], i == BLOCK_WORDS - 1);
        return;
      end
      staged[staged_cnt] = w;
      staged_cnt++;
      if (staged_cnt < BLOCK_WORDS) return;
      staged_cnt = 0;
      if (f == FUNC_UPDATE) begin
        idx = find_key(d, b);
        if (idx < 0) begin
          push(ST_MISS, '0, 1'b1);
          return;
        end
        blocks[idx] = staged;
        bump(idx);
        push(ST_OK, '0, 1'b1);
        return;
      end
      // insert: first free slot, else fewest uses, lowest index on a tie
      victim = 0;
      have = 0;
      dup = 0;
      best = '0;
      for (int i = 0; i < entries; i++) begin
        if (!valid[i]) begin
          victim = i;
          have = 1;
          break;
        end
        if (tag_disk[i] == d && tag_block[i] == b) begin
          dup = 1;
          break;
        end
        if (!have || uses[i] < best) begin
          best = uses[i];
          victim = i;
          have = 1;
        end
      end
      if (dup) begin
        push(ST_DUP, '0, 1'b1);
        return;
      end
      valid[victim] = 1;
      tag_disk[victim] = d;
      tag_block[victim] = b;
      uses[victim] = USE_COUNT_WIDTH'(1);
      blocks[victim] = staged;
      push(ST_OK, '0, 1'b1);
    endfunction

    function void check_result(cache_result_t got);
      cache_result_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word: status %0d word %h",
                                   got.status, got.rword);
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status || got.rword !== exp.rword ||
          got.last !== exp.last || got.hits !== exp.hits ||
          got.queries !== exp.queries) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: exp st %0d w %h l %0d h %0d q %0d",
                    " / got st %0d w %h l %0d h %0d q %0d"},
                   exp.status, exp.rword, exp.last, exp.hits, exp.queries,
                   got.status, got.rword, got.last, got.hits, got.queries);
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 3000000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [79:0]  s_tdata = '0;   // disk[3:0], block[11:4], data_word[75:12], pad
  logic [1:0]   s_tuser = FUNC_NONE;  // func[1:0]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;        // status[1:0], read_word[65:2], hit_total[97:66],
                                // query_total[129:98], pad
  logic         m_tlast;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  cache_scoreboard sb = new();
  int cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;
  logic [3:0] key_disk [6] = '{4'd0, 4'd15, 4'd5, 4'd10, 4'd0, 4'd15};
  logic [7:0] key_block [6] = '{8'd0, 8'd255, 8'h5a, 8'ha5, 8'd255, 8'd0};

  lfu_block_cache_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: check accepted words, stall on a pattern that changes mode
  always @(posedge clk) begin
    cache_result_t got;
    if (m_tvalid && m_tready && !rst) begin
      got.status = m_tdata[1:0];
      got.rword = m_tdata[65:2];
      got.hits = m_tdata[97:66];
      got.queries = m_tdata[129:98];
      got.last = m_tlast;
      sb.check_result(got);
    end
    if (cycles % 500 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= (cycles % 7) > 2;
      default: m_tready <= $urandom_range(0, 3) != 0;
    endcase
  end

  // Send one word; valid stays high within a burst, drops for a gap after it
  task automatic send_word(logic [1:0] f, logic [3:0] d, logic [7:0] b,
                           logic [63:0] w);
    s_tvalid <= 1'b1;
    s_tuser <= f;
    s_tdata <= {4'b0, w, b, d};
    do @(posedge clk); while (!s_tready);
    sb.note_word(f, d, b, w);
    if (burst_left > 0) burst_left--;
    else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 8);
    end
  endtask

  // Hold input until every expected word is back and the core is idle
  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic reg_write(logic r, logic [31:0] val);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {1'b0, r, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(r, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Stage a whole block; earlier words may carry either write func
  task automatic write_block(logic [1:0] f, logic [3:0] d, logic [7:0] b,
                             bit mixed, int pattern);
    logic [63:0] w;
    logic [1:0] fw;
    for (int i = 0; i < BLOCK_WORDS; i++) begin
      case (pattern)
        0: w = (i % 2) ? '1 : '0;
        default: w = rand_word();
      endcase
      fw = (mixed && i < BLOCK_WORDS - 1) ?
           (($urandom_range(0, 1) != 0) ? FUNC_INSERT : FUNC_UPDATE) : f;
      send_word(fw, d, b, w);
    end
  endtask

  // Random phase: lookups on a small key pool, block writes, some noise
  task automatic random_phase(int quota);
    int sent;
    int k;
    int sel;
    logic [3:0] d;
    logic [7:0] b;
    sent = 0;
    while (sent < quota) begin
      k = $urandom_range(0, 5);
      d = key_disk[k];
      b = key_block[k];
      if ($urandom_range(0, 9) == 0) begin
        d = 4'($urandom());
        b = 8'($urandom());
      end
      sel = $urandom_range(0, 19);
      if (sel < 10) begin
        send_word(FUNC_LOOKUP, d, b, rand_word());
        sent++;
      end else if (sel < 16) begin
        // a whole block only while it fits in the phase's word budget
        if (sent + BLOCK_WORDS <= quota) begin
          write_block(($urandom_range(0, 2) != 0) ? FUNC_INSERT : FUNC_UPDATE, d, b,
                      $urandom_range(0, 3) == 0, 1);
          sent += BLOCK_WORDS;
        end else begin
          send_word(FUNC_LOOKUP, d, b, rand_word());
          sent++;
        end
      end else if (sel < 18) begin
        // partial staging, completed by a later write
        repeat ($urandom_range(1, 10)) begin
          send_word(FUNC_INSERT, d, b, rand_word());
          sent++;
        end
      end else begin
        send_word(FUNC_NONE, d, b, rand_word());
        sent++;
      end
    end
  endtask

  initial begin
    sb.reset_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // disabled after reset; undefined func ignored
    send_word(FUNC_LOOKUP, 4'd0, 8'd0, '0);
    send_word(FUNC_INSERT, 4'd15, 8'd255, '1);
    send_word(FUNC_UPDATE, 4'd3, 8'd7, '0);
    send_word(FUNC_NONE, 4'd1, 8'd1, '1);

    // two entries: miss, insert, duplicate, hit, update, absent update, eviction
    reg_write(REG_ENABLED, 32'd1);
    reg_write(REG_ENTRIES, 32'd0);
    send_word(FUNC_LOOKUP, 4'd15, 8'd255, '1);
    write_block(FUNC_INSERT, 4'd15, 8'd255, 0, 0);
    write_block(FUNC_INSERT, 4'd15, 8'd255, 1, 1);
    send_word(FUNC_LOOKUP, 4'd15, 8'd255, '0);
    write_block(FUNC_UPDATE, 4'd15, 8'd255, 0, 1);
    write_block(FUNC_UPDATE, 4'd0, 8'd0, 0, 1);
    write_block(FUNC_INSERT, 4'd0, 8'd0, 0, 1);
    write_block(FUNC_INSERT, 4'd5, 8'd90, 0, 1);
    send_word(FUNC_LOOKUP, 4'd0, 8'd0, '0);
    send_word(FUNC_LOOKUP, 4'd5, 8'd90, '0);
    send_word(FUNC_LOOKUP, 4'd15, 8'd255, '0);

    // pause until everything is back, then carry on
    drain();
    random_phase(36);

    reg_write(REG_ENTRIES, 32'd3);
    random_phase(6);
    reg_write(REG_ENTRIES, 32'h0000_0204);
    random_phase(6);
    reg_write(REG_ENTRIES, 32'd1);
    random_phase(6);
    reg_write(REG_ENABLED, 32'hffff_fffe);
    random_phase(4);
    reg_write(REG_ENABLED, 32'd1);
    reg_write(REG_ENTRIES, 32'd256);
    random_phase(6);
    reg_write(REG_ENTRIES, 32'hffff_ffff);
    random_phase(6);

    drain();
    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/lfu_pkg.sv
rtl/lfu_block_cache_core.sv
test/lfu_block_cache_core_test.sv
